/* sv/hdlc_pkg.sv */
// ----------------------------------------------------------------------------
// hdlc_pkg
// Shared constants and control types for the HDLC frame transmitter.
// ----------------------------------------------------------------------------
package hdlc_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [2:0]  STUFF_RUN = 3'd5;

  // per-cycle command to the shared line bit unit
  typedef struct packed {
    logic fire;      // one line bit goes out this cycle
    logic bit_val;   // source bit
    logic stuffed;   // bit goes through the ones counter
    logic ins;       // this is an inserted zero
    logic crc_en;    // fold the bit into the crc
    logic crc_init;  // restart the crc after this cycle
  } bit_ctrl_t;

  typedef struct packed {
    logic        line;          // line level for the bit now fired
    logic        stuff_follow;  // a zero must be inserted next
    logic [15:0] crc;           // crc including the bit now fired
  } bit_stat_t;

endpackage

/* sv/hdlc_bit_unit.sv */
// ----------------------------------------------------------------------------
// hdlc_bit_unit
// Shared unit, one bit per cycle while ctrl fire is set: zero insertion count,
// crc-16 update and nrzi line level.
// ----------------------------------------------------------------------------
module hdlc_bit_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  hdlc_pkg::bit_ctrl_t ctrl_i,
  output hdlc_pkg::bit_stat_t stat_o
);
  import hdlc_pkg::*;

  logic [15:0] crc_r, crc_nxt, crc_upd;
  logic [2:0]  ones_r, ones_nxt;
  logic        line_r, line_nxt;
  logic        bit_eff, fb;

  always_comb begin
    bit_eff  = ctrl_i.ins ? 1'b0 : ctrl_i.bit_val;
    ones_nxt = ones_r;
    line_nxt = line_r;
    if (ctrl_i.fire) begin
      if (ctrl_i.ins) begin
        ones_nxt = '0;
      end else if (ctrl_i.stuffed) begin
        ones_nxt = bit_eff ? ones_r + 3'd1 : 3'd0;
      end
      if (!bit_eff) begin
        line_nxt = ~line_r;
      end
    end
    // reflected crc, one bit lsb first
    fb      = crc_r[0] ^ bit_eff;
    crc_upd = {1'b0, crc_r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    crc_nxt = (ctrl_i.fire && ctrl_i.crc_en) ? crc_upd : crc_r;
  end

  assign stat_o.line         = line_nxt;
  assign stat_o.stuff_follow = ctrl_i.fire && ctrl_i.stuffed && !ctrl_i.ins &&
                               (ones_nxt >= STUFF_RUN);
  assign stat_o.crc          = crc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      ones_r <= '0;
      line_r <= 1'b0;
    end else begin
      crc_r  <= ctrl_i.crc_init ? CRC_INIT : crc_nxt;
      ones_r <= ones_nxt;
      line_r <= line_nxt;
    end
  end

  // count never passes the run length
  a_ones_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ones_r <= STUFF_RUN)
    else $error("ones count beyond run length");

  // an inserted zero only follows a full run of ones
  a_ins_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_i.fire && ctrl_i.ins) |-> ones_r == STUFF_RUN)
    else $error("zero inserted without a run of ones");

  // a full run of ones is always answered by an insertion
  a_run_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_i.fire && ones_r == STUFF_RUN) |-> ctrl_i.ins)
    else $error("run of ones not followed by inserted zero");

endmodule

/* sv/hdlc_frame_transmitter_top.sv */
// ----------------------------------------------------------------------------
// hdlc_frame_transmitter_top
// HDLC transmitter: flags, bit stuffing, crc-16 trailer and nrzi coding,
// one line bit per cycle through a shared bit unit when out_ is not stalled.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: data_byte, tuser: op, first_byte;
//          |     |                    | tlast: last_byte
//  out_    | out | out_tvalid/tready  | tdata: line_bit, tlast: run_end
//
//  one line bit per cycle when out_ is not stalled. a first and last byte
//  goes out as opening flag, data byte, crc trailer and closing flag.
//  in_tready is high only while no word is being serialized.
//  reset clears crc to all ones, ones count, line level and the sequencer.
//  a stall on out_ holds the sequencer and the bit unit.
// ----------------------------------------------------------------------------
module hdlc_frame_transmitter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [0] op, [1] first_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] line_bit, [7:1] zero
  output logic       out_tlast   // run_end
);
  import hdlc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FLAG, S_OPEN, S_DATA, S_CRC, S_CLOSE
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] sreg_r, sreg_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        last_r, last_nxt;
  logic        stuff_pend_r, stuff_pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_bit_r, out_bit_nxt;
  logic        out_last_r, out_last_nxt;

  logic        accept, fire, advance, seg_end, crc_init;
  bit_ctrl_t   ctrl;
  bit_stat_t   stat;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign fire      = (state_r != S_IDLE) && (!out_valid_r || out_tready);
  assign seg_end   = (cnt_r == ((state_r == S_CRC) ? 4'd15 : 4'd7));
  assign advance   = fire && (stuff_pend_r || !stat.stuff_follow);

  assign ctrl.fire     = fire;
  assign ctrl.bit_val  = sreg_r[0];
  assign ctrl.ins      = stuff_pend_r;
  assign ctrl.stuffed  = (state_r == S_DATA) || (state_r == S_CRC) ||
                         ((state_r == S_OPEN) && (cnt_r == 4'd7));
  assign ctrl.crc_en   = (state_r == S_DATA) && !stuff_pend_r;
  assign ctrl.crc_init = crc_init;

  hdlc_bit_unit u_bit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    sreg_nxt       = sreg_r;
    data_nxt       = data_r;
    last_nxt       = last_r;
    stuff_pend_nxt = stuff_pend_r;
    out_valid_nxt  = out_valid_r;
    out_bit_nxt    = out_bit_r;
    out_last_nxt   = out_last_r;
    crc_init       = 1'b0;

    if (accept) begin
      data_nxt = in_tdata;
      last_nxt = in_tlast;
      cnt_nxt  = '0;
      if (in_tuser[0]) begin
        state_nxt = S_FLAG;
        sreg_nxt  = {8'h00, FLAG_BYTE};
      end else if (in_tuser[1]) begin
        state_nxt = S_OPEN;
        sreg_nxt  = {8'h00, FLAG_BYTE};
        crc_init  = 1'b1;
      end else begin
        state_nxt = S_DATA;
        sreg_nxt  = {8'h00, in_tdata};
      end
    end

    if (fire) begin
      stuff_pend_nxt = stat.stuff_follow;
      out_valid_nxt  = 1'b1;
      out_bit_nxt    = stat.line;
      out_last_nxt   = 1'b0;
      if (advance) begin
        if (!seg_end) begin
          sreg_nxt = {1'b0, sreg_r[15:1]};
          cnt_nxt  = cnt_r + 4'd1;
        end else begin
          cnt_nxt = '0;
          unique case (state_r)
            S_OPEN: begin
              state_nxt = S_DATA;
              sreg_nxt  = {8'h00, data_r};
            end
            S_DATA: begin
              if (last_r) begin
                state_nxt = S_CRC;
                sreg_nxt  = stat.crc ^ CRC_INIT;
                crc_init  = 1'b1;
              end else begin
                state_nxt    = S_IDLE;
                out_last_nxt = 1'b1;
              end
            end
            S_CRC: begin
              state_nxt = S_CLOSE;
              sreg_nxt  = {8'h00, FLAG_BYTE};
            end
            S_FLAG, S_CLOSE: begin
              state_nxt    = S_IDLE;
              out_last_nxt = 1'b1;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      stuff_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      stuff_pend_r <= stuff_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      out_last_r   <= out_last_nxt;
    end
    sreg_r    <= sreg_nxt;
    data_r    <= data_nxt;
    last_r    <= last_nxt;
    out_bit_r <= out_bit_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, out_bit_r};
  assign out_tlast  = out_last_r;

  // a pending zero insertion keeps the sequencer busy
  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stuff_pend_r |-> (state_r == S_DATA || state_r == S_CRC))
    else $error("stuffing pending outside a stuffed segment");

  // byte-long segments never count past seven
  a_cnt_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CRC) |-> !cnt_r[3])
    else $error("bit counter past byte length");

  // the word that ends an item is followed by an idle sequencer
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("item end without return to idle");

endmodule
